@@ rtl/core/i2cm_pkg.sv @@
`default_nettype none
package i2cm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_A     = 5'd1,
        PH_ST_B     = 5'd2,
        PH_ST_C     = 5'd3,
        PH_RS_A     = 5'd4,
        PH_W_RISE   = 5'd5,
        PH_W_STR    = 5'd6,
        PH_W_SAMP   = 5'd7,
        PH_W_FALL   = 5'd8,
        PH_W_END    = 5'd9,
        PH_R_RISE   = 5'd10,
        PH_R_STR    = 5'd11,
        PH_R_SAMP   = 5'd12,
        PH_R_FALL   = 5'd13,
        PH_R_END    = 5'd14,
        PH_SP_A     = 5'd15,
        PH_SP_B     = 5'd16,
        PH_SP_C     = 5'd17,
        PH_RC_CHECK = 5'd18,
        PH_RC_HIGH  = 5'd19
    } phase_t;

    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_START   = 3'd1;
    localparam logic [2:0] MODE_WRITE   = 3'd2;
    localparam logic [2:0] MODE_READ    = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;
    localparam logic [2:0] MODE_RECOVER = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_ACK   = 3'd1;
    localparam logic [2:0] ST_WR_FAIL  = 3'd2;
    localparam logic [2:0] ST_RD_TOUT  = 3'd3;
    localparam logic [2:0] ST_RECOVERY = 3'd4;

    localparam logic [1:0] CFG_QUARTER = 2'd0;
    localparam logic [1:0] CFG_HALF    = 2'd1;
    localparam logic [1:0] CFG_STRETCH = 2'd2;
    localparam logic [1:0] CFG_PULSES  = 2'd3;

    typedef struct packed {
        logic [15:0] quarter;
        logic [15:0] half;
        logic [23:0] stretch;
        logic [4:0]  pulses;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] target_address;
        logic       read_not_write;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       sda_in;
        logic       scl_in;
    } tick_t;

    typedef struct packed {
        logic       sda_low;
        logic       scl_low;
        logic [7:0] rx_byte;
        logic       command_done;
        logic [2:0] status;
        logic       busy_res;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/i2cm_cfg.sv @@
`default_nettype none
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [23:0] cfg_data,
    output cfg_t             cfg
);
    cfg_t cfg_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quarter <= 16'd600;
            cfg_reg.half    <= 16'd1200;
            cfg_reg.stretch <= 24'd240000;
            cfg_reg.pulses  <= 5'd9;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_QUARTER: cfg_reg.quarter <= cfg_data[15:0];
                CFG_HALF:    cfg_reg.half    <= cfg_data[15:0];
                CFG_STRETCH: cfg_reg.stretch <= cfg_data;
                CFG_PULSES:  cfg_reg.pulses  <= cfg_data[4:0];
                default:     cfg_reg.pulses  <= cfg_reg.pulses;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

@@ rtl/core/i2cm_engine.sv @@
`default_nettype none
module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire cfg_t  cfg,
    input  wire tick_t tick,
    output result_t    res
);
    phase_t      phase_reg, phase_next;
    logic [15:0] period_reg, period_next;
    logic [23:0] stretch_reg, stretch_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [4:0]  pulse_reg, pulse_next;
    logic        sda_reg, sda_next, scl_reg, scl_next;
    logic        held_reg, held_next;
    logic [2:0]  status_reg, status_next;
    logic        done;
    logic [7:0]  rx;
    logic [15:0] qtr, hlf, pdec;
    logic [3:0]  bi1;

    assign qtr  = (cfg.quarter == 16'd0) ? 16'd1 : cfg.quarter;
    assign hlf  = (cfg.half == 16'd0) ? 16'd1 : cfg.half;
    assign pdec = period_reg - 16'd1;
    assign bi1  = bit_reg + 4'd1;

    // next state for one tick
    always_comb begin
        phase_next   = phase_reg;
        period_next  = period_reg;
        stretch_next = stretch_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        pulse_next   = pulse_reg;
        sda_next     = sda_reg;
        scl_next     = scl_reg;
        held_next    = held_reg;
        status_next  = status_reg;
        done         = 1'b0;
        rx           = 8'd0;
        if (phase_reg == PH_IDLE) begin
            if (tick.mode == MODE_START) begin
                shift_next = {tick.target_address, tick.read_not_write};
                sda_next   = 1'b0;
                if (held_reg) begin
                    phase_next = PH_RS_A; period_next = qtr;
                end else begin
                    scl_next = 1'b0; phase_next = PH_ST_A; period_next = hlf;
                end
            end else if (tick.mode == MODE_WRITE && held_reg) begin
                shift_next = tick.tx_byte; bit_next = 4'd0;
                sda_next = ~tick.tx_byte[7]; phase_next = PH_W_RISE; period_next = qtr;
            end else if (tick.mode == MODE_READ && held_reg) begin
                shift_next = 8'd0; bit_next = 4'd0; pulse_next = {4'd0, tick.last_byte};
                sda_next = 1'b0; phase_next = PH_R_RISE; period_next = qtr;
            end else if (tick.mode == MODE_STOP && held_reg) begin
                status_next = ST_OK; sda_next = 1'b1;
                phase_next = PH_SP_A; period_next = qtr;
            end else if (tick.mode == MODE_RECOVER) begin
                status_next = ST_RECOVERY; sda_next = 1'b0; scl_next = 1'b0;
                pulse_next = 5'd0; phase_next = PH_RC_CHECK; period_next = hlf;
            end
        end else if (phase_reg == PH_W_STR || phase_reg == PH_R_STR) begin
            // clock stretch wait
            if (tick.scl_in) begin
                phase_next  = (phase_reg == PH_W_STR) ? PH_W_SAMP : PH_R_SAMP;
                period_next = qtr;
            end else if (stretch_reg >= cfg.stretch) begin
                if (phase_reg == PH_W_STR && bit_reg[3]) begin
                    status_next = ST_OK; phase_next = PH_IDLE; done = 1'b1; rx = shift_reg;
                end else if (phase_reg == PH_W_STR || bit_reg[3]) begin
                    sda_next = 1'b0; scl_next = 1'b0; held_next = 1'b0;
                    status_next = ST_WR_FAIL; phase_next = PH_IDLE; done = 1'b1;
                end else begin
                    status_next = ST_RD_TOUT; sda_next = 1'b1;
                    phase_next = PH_SP_A; period_next = qtr;
                end
            end else begin
                stretch_next = stretch_reg + 24'd1;
            end
        end else begin
            period_next = pdec;
            if (pdec == 16'd0) begin
                unique case (phase_reg)
                    PH_ST_A: begin
                        sda_next = 1'b1; phase_next = PH_ST_B; period_next = hlf;
                    end
                    PH_ST_B: begin
                        scl_next = 1'b1; phase_next = PH_ST_C; period_next = qtr;
                    end
                    PH_ST_C: begin
                        bit_next = 4'd0; sda_next = ~shift_reg[7];
                        phase_next = PH_W_RISE; period_next = qtr;
                    end
                    PH_RS_A: begin
                        scl_next = 1'b0; phase_next = PH_ST_A; period_next = hlf;
                    end
                    PH_W_RISE: begin
                        scl_next = 1'b0; stretch_next = 24'd0; phase_next = PH_W_STR;
                    end
                    PH_R_RISE: begin
                        scl_next = 1'b0; stretch_next = 24'd0; phase_next = PH_R_STR;
                    end
                    PH_W_SAMP: begin
                        if (!sda_reg && !tick.sda_in) begin
                            // lost arbitration or released ack
                            if (bit_reg[3]) begin
                                status_next = ST_OK; phase_next = PH_IDLE;
                                done = 1'b1; rx = shift_reg;
                            end else begin
                                sda_next = 1'b0; scl_next = 1'b0; held_next = 1'b0;
                                status_next = ST_WR_FAIL; phase_next = PH_IDLE; done = 1'b1;
                            end
                        end else begin
                            phase_next = PH_W_FALL; period_next = qtr;
                        end
                    end
                    PH_R_SAMP: begin
                        shift_next = {shift_reg[6:0], tick.sda_in};
                        phase_next = PH_R_FALL; period_next = qtr;
                    end
                    PH_W_FALL: begin
                        scl_next = 1'b1; phase_next = PH_W_END; period_next = qtr;
                    end
                    PH_R_FALL: begin
                        scl_next = 1'b1; phase_next = PH_R_END; period_next = qtr;
                    end
                    PH_W_END: begin
                        if (bit_reg[3]) begin
                            status_next = ST_OK; phase_next = PH_IDLE;
                            done = 1'b1; rx = shift_reg;
                        end else begin
                            bit_next = bi1; period_next = qtr;
                            if (!bi1[3]) begin
                                sda_next = ~shift_reg[3'd7 - bi1[2:0]];
                                phase_next = PH_W_RISE;
                            end else begin
                                sda_next = 1'b0; phase_next = PH_R_RISE;
                            end
                        end
                    end
                    PH_R_END: begin
                        if (bit_reg[3]) begin
                            if (shift_reg[0]) begin
                                status_next = ST_NO_ACK; sda_next = 1'b1;
                                phase_next = PH_SP_A; period_next = qtr;
                            end else begin
                                held_next = 1'b1; status_next = ST_OK;
                                phase_next = PH_IDLE; done = 1'b1;
                            end
                        end else begin
                            bit_next = bi1; period_next = qtr;
                            if (!bi1[3]) begin
                                sda_next = 1'b0; phase_next = PH_R_RISE;
                            end else begin
                                sda_next = ~pulse_reg[0]; phase_next = PH_W_RISE;
                            end
                        end
                    end
                    PH_SP_A: begin
                        scl_next = 1'b0; phase_next = PH_SP_B; period_next = hlf;
                    end
                    PH_SP_B: begin
                        sda_next = 1'b0; phase_next = PH_SP_C; period_next = hlf;
                    end
                    PH_SP_C: begin
                        held_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                        if (status_reg == ST_RECOVERY)
                            status_next = (tick.sda_in && tick.scl_in) ? ST_OK : ST_RECOVERY;
                    end
                    PH_RC_CHECK: begin
                        if (tick.sda_in || pulse_reg >= cfg.pulses) begin
                            sda_next = 1'b1; phase_next = PH_SP_A; period_next = qtr;
                        end else begin
                            scl_next = 1'b1; pulse_next = pulse_reg + 5'd1;
                            phase_next = PH_RC_HIGH; period_next = hlf;
                        end
                    end
                    PH_RC_HIGH: begin
                        scl_next = 1'b0; phase_next = PH_RC_CHECK; period_next = hlf;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            period_reg  <= 16'd0;
            stretch_reg <= 24'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            pulse_reg   <= 5'd0;
            sda_reg     <= 1'b0;
            scl_reg     <= 1'b0;
            held_reg    <= 1'b0;
            status_reg  <= ST_OK;
        end else if (step) begin
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            stretch_reg <= stretch_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pulse_reg   <= pulse_next;
            sda_reg     <= sda_next;
            scl_reg     <= scl_next;
            held_reg    <= held_next;
            status_reg  <= status_next;
        end
    end

    always_comb begin
        res.sda_low      = sda_next;
        res.scl_low      = scl_next;
        res.rx_byte      = rx;
        res.command_done = done;
        res.status       = status_next;
        res.busy_res     = (phase_next != PH_IDLE);
    end
endmodule
`default_nettype wire

@@ rtl/core/i2c_master_controller.sv @@
// i2c master timing engine, one input item per bus tick
// result: the result of an item appears in the cycle after acceptance (result register)
// throughput: 1 item per cycle, stalled by m_ready; a held result leaves as the next enters
// reset: aresetn synchronous active low; lines released, idle, timing registers at defaults
`default_nettype none
module i2c_master_controller
    import i2cm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [6:0]  s_target_address,
    input  wire logic        s_read_not_write,
    input  wire logic [7:0]  s_tx_byte,
    input  wire logic        s_last_byte,
    input  wire logic        s_sda_in,
    input  wire logic        s_scl_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_sda_low,
    output logic             m_scl_low,
    output logic [7:0]       m_rx_byte,
    output logic             m_command_done,
    output logic [2:0]       m_status,
    output logic             m_busy_res
);
    cfg_t    cfg;
    tick_t   tick;
    result_t res, res_reg;
    logic    valid_reg, step;

    assign s_ready = !valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign tick    = '{s_mode, s_target_address, s_read_not_write, s_tx_byte,
                       s_last_byte, s_sda_in, s_scl_in};

    i2cm_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we),
        .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cfg(cfg)
    );

    i2cm_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .cfg(cfg), .tick(tick), .res(res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_sda_low      = res_reg.sda_low;
    assign m_scl_low      = res_reg.scl_low;
    assign m_rx_byte      = res_reg.rx_byte;
    assign m_command_done = res_reg.command_done;
    assign m_status       = res_reg.status;
    assign m_busy_res     = res_reg.busy_res;
endmodule
`default_nettype wire

@@ rtl/core/i2cm_checker.sv @@
`default_nettype none
module i2cm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_rx_byte,
    input wire logic       m_command_done,
    input wire logic [2:0] m_status
);
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    // no room only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without cause");

    // received data only with done
    a_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_command_done |-> m_rx_byte == 8'd0)
        else $error("rx byte without done");

    // accepted item yields a result
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("result missing");
endmodule

bind i2c_master_controller i2cm_checker u_i2cm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_rx_byte(m_rx_byte),
    .m_command_done(m_command_done), .m_status(m_status)
);
`default_nettype wire

@@ dv/tb_i2c_master_controller.sv @@
`default_nettype none
module tb_i2c_master_controller;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [23:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic [6:0]  s_target_address;
    logic        s_read_not_write;
    logic [7:0]  s_tx_byte;
    logic        s_last_byte;
    logic        s_sda_in;
    logic        s_scl_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_sda_low;
    logic        m_scl_low;
    logic [7:0]  m_rx_byte;
    logic        m_command_done;
    logic [2:0]  m_status;
    logic        m_busy_res;

    i2c_master_controller i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_target_address(s_target_address), .s_read_not_write(s_read_not_write),
        .s_tx_byte(s_tx_byte), .s_last_byte(s_last_byte),
        .s_sda_in(s_sda_in), .s_scl_in(s_scl_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sda_low(m_sda_low), .m_scl_low(m_scl_low), .m_rx_byte(m_rx_byte),
        .m_command_done(m_command_done), .m_status(m_status), .m_busy_res(m_busy_res)
    );

    // clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // bus engine predictor state
    cfg_t        cfg;
    phase_t      ph;
    logic [15:0] p_count;
    logic [23:0] s_count;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [4:0]  pulses;
    logic        sda_drv, scl_drv, held;
    logic [2:0]  last_st;
    logic        done_flag;
    logic [7:0]  rx_val;

    tick_t   tick_q[$];
    result_t bus_result_q[$];

    int errors;
    int n_items;
    int n_results;
    int n_done;

    function automatic void bus_reset_state();
        cfg.quarter = 16'd600;
        cfg.half = 16'd1200;
        cfg.stretch = 24'd240000;
        cfg.pulses = 5'd9;
        ph = PH_IDLE;
        p_count = '0; s_count = '0; bit_idx = '0; shreg = '0; pulses = '0;
        sda_drv = 1'b0; scl_drv = 1'b0; held = 1'b0; last_st = ST_OK;
    endfunction

    function automatic void go_to(phase_t nxt, logic [15:0] cyc);
        ph = nxt;
        p_count = (cyc == 16'd0) ? 16'd1 : cyc;
    endfunction

    function automatic void send_bit(logic v);
        sda_drv = ~v;
        go_to(PH_W_RISE, cfg.quarter);
    endfunction

    function automatic void recv_bit();
        sda_drv = 1'b0;
        go_to(PH_R_RISE, cfg.quarter);
    endfunction

    function automatic void send_byte(logic [7:0] b);
        shreg = b;
        bit_idx = '0;
        send_bit(b[7]);
    endfunction

    function automatic void send_stop();
        sda_drv = 1'b1;
        go_to(PH_SP_A, cfg.quarter);
    endfunction

    function automatic void end_cmd(logic [2:0] st, logic [7:0] rx);
        last_st = st;
        ph = PH_IDLE;
        done_flag = 1'b1;
        rx_val = rx;
    endfunction

    function automatic void release_fail();
        sda_drv = 1'b0;
        scl_drv = 1'b0;
        held = 1'b0;
        end_cmd(ST_WR_FAIL, 8'd0);
    endfunction

    function automatic void write_bit_fail();
        if (bit_idx >= 4'd8) end_cmd(ST_OK, shreg);
        else release_fail();
    endfunction

    function automatic void read_bit_fail();
        if (bit_idx >= 4'd8) begin
            release_fail();
        end else begin
            last_st = ST_RD_TOUT;
            send_stop();
        end
    endfunction

    function automatic void bus_advance(logic sda, logic scl);
        if (ph == PH_W_STR || ph == PH_R_STR) begin
            if (scl) go_to(phase_t'(ph + 5'd1), cfg.quarter);
            else if (s_count >= cfg.stretch) begin
                if (ph == PH_W_STR) write_bit_fail();
                else read_bit_fail();
            end else s_count = s_count + 24'd1;
            return;
        end
        p_count = p_count - 16'd1;
        if (p_count != 16'd0) return;
        case (ph)
            PH_ST_A: begin sda_drv = 1'b1; go_to(PH_ST_B, cfg.half); end
            PH_ST_B: begin scl_drv = 1'b1; go_to(PH_ST_C, cfg.quarter); end
            PH_ST_C: send_byte(shreg);
            PH_RS_A: begin scl_drv = 1'b0; go_to(PH_ST_A, cfg.half); end
            PH_W_RISE, PH_R_RISE: begin
                scl_drv = 1'b0;
                s_count = '0;
                ph = phase_t'(ph + 5'd1);
            end
            PH_W_SAMP: begin
                if (!sda_drv && !sda) write_bit_fail();
                else go_to(PH_W_FALL, cfg.quarter);
            end
            PH_R_SAMP: begin
                shreg = {shreg[6:0], sda};
                go_to(PH_R_FALL, cfg.quarter);
            end
            PH_W_FALL: begin scl_drv = 1'b1; go_to(PH_W_END, cfg.quarter); end
            PH_R_FALL: begin scl_drv = 1'b1; go_to(PH_R_END, cfg.quarter); end
            PH_W_END: begin
                if (bit_idx >= 4'd8) end_cmd(ST_OK, shreg);
                else begin
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx < 4'd8) send_bit(shreg[3'd7 - bit_idx[2:0]]);
                    else recv_bit();
                end
            end
            PH_R_END: begin
                if (bit_idx >= 4'd8) begin
                    if (shreg[0]) begin
                        last_st = ST_NO_ACK;
                        send_stop();
                    end else begin
                        held = 1'b1;
                        end_cmd(ST_OK, 8'd0);
                    end
                end else begin
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx < 4'd8) recv_bit();
                    else send_bit(pulses[0]);
                end
            end
            PH_SP_A: begin scl_drv = 1'b0; go_to(PH_SP_B, cfg.half); end
            PH_SP_B: begin sda_drv = 1'b0; go_to(PH_SP_C, cfg.half); end
            PH_SP_C: begin
                held = 1'b0;
                if (last_st == ST_RECOVERY)
                    end_cmd((sda && scl) ? ST_OK : ST_RECOVERY, 8'd0);
                else end_cmd(last_st, 8'd0);
            end
            PH_RC_CHECK: begin
                if (sda || pulses >= cfg.pulses) send_stop();
                else begin
                    scl_drv = 1'b1;
                    pulses = pulses + 5'd1;
                    go_to(PH_RC_HIGH, cfg.half);
                end
            end
            PH_RC_HIGH: begin scl_drv = 1'b0; go_to(PH_RC_CHECK, cfg.half); end
            default: ph = PH_IDLE;
        endcase
    endfunction

    function automatic result_t bus_tick(tick_t t);
        result_t r;
        done_flag = 1'b0;
        rx_val = 8'd0;
        if (ph != PH_IDLE) begin
            bus_advance(t.sda_in, t.scl_in);
        end else if (t.mode == MODE_START) begin
            shreg = {t.target_address, t.read_not_write};
            sda_drv = 1'b0;
            if (held) go_to(PH_RS_A, cfg.quarter);
            else begin
                scl_drv = 1'b0;
                go_to(PH_ST_A, cfg.half);
            end
        end else if (t.mode == MODE_WRITE && held) begin
            send_byte(t.tx_byte);
        end else if (t.mode == MODE_READ && held) begin
            shreg = '0;
            bit_idx = '0;
            pulses = {4'd0, t.last_byte};
            recv_bit();
        end else if (t.mode == MODE_STOP && held) begin
            last_st = ST_OK;
            send_stop();
        end else if (t.mode == MODE_RECOVER) begin
            last_st = ST_RECOVERY;
            sda_drv = 1'b0;
            scl_drv = 1'b0;
            pulses = '0;
            go_to(PH_RC_CHECK, cfg.half);
        end
        r.sda_low = sda_drv;
        r.scl_low = scl_drv;
        r.rx_byte = rx_val;
        r.command_done = done_flag;
        r.status = last_st;
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    // random gap length: mostly short, sometimes long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // bus-level stimulus: sda/scl with a slave that mostly behaves
    logic slave_mode;
    logic stuck_sda;

    function automatic tick_t mk_tick(logic [2:0] mode);
        tick_t t;
        t.mode = mode;
        t.target_address = 7'($urandom_range(0, 127));
        t.read_not_write = 1'($urandom_range(0, 1));
        t.tx_byte = 8'($urandom_range(0, 255));
        t.last_byte = 1'($urandom_range(0, 1));
        if (slave_mode) begin
            t.scl_in = ($urandom_range(0, 9) != 0);
            t.sda_in = stuck_sda ? 1'b0 : ($urandom_range(0, 3) != 0);
        end else begin
            t.scl_in = 1'($urandom_range(0, 1));
            t.sda_in = 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    // queue n ticks with a command in front
    task automatic push_cmd(logic [2:0] mode, int n);
        tick_t t;
        t = mk_tick(mode);
        tick_q.push_back(t);
        for (int i = 1; i < n; i++) tick_q.push_back(mk_tick(MODE_NONE));
    endtask

    task automatic wait_drain();
        while (tick_q.size() != 0 || bus_result_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(int q, int h, int st, int pl);
        write_reg(CFG_QUARTER, q[23:0]);
        write_reg(CFG_HALF, h[23:0]);
        write_reg(CFG_STRETCH, st[23:0]);
        write_reg(CFG_PULSES, pl[23:0]);
    endtask

    // a phase of mostly well-formed transactions, noise in the rest
    task automatic run_phase(int n_cmds, int q, int h);
        int len;
        int p;
        len = 40 * (q + h) + 60;
        for (int c = 0; c < n_cmds; c++) begin
            p = $urandom_range(0, 99);
            slave_mode = ($urandom_range(0, 9) != 0);
            stuck_sda = ($urandom_range(0, 4) == 0);
            if (p < 20) push_cmd(MODE_START, len);
            else if (p < 45) push_cmd(MODE_WRITE, len);
            else if (p < 65) push_cmd(MODE_READ, len);
            else if (p < 78) push_cmd(MODE_STOP, len / 4);
            else if (p < 86) push_cmd(MODE_RECOVER, len);
            else push_cmd(3'($urandom_range(0, 7)), $urandom_range(1, 6));
        end
    endtask

    // driver
    int in_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) void'(tick_q.pop_front());
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (tick_q.size() != 0) begin
                s_valid <= 1'b1;
                s_mode <= tick_q[0].mode;
                s_target_address <= tick_q[0].target_address;
                s_read_not_write <= tick_q[0].read_not_write;
                s_tx_byte <= tick_q[0].tx_byte;
                s_last_byte <= tick_q[0].last_byte;
                s_sda_in <= tick_q[0].sda_in;
                s_scl_in <= tick_q[0].scl_in;
                in_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // predictor fed at acceptance
    always @(posedge aclk) begin
        tick_t t;
        if (aresetn && s_valid && s_ready) begin
            t = {s_mode, s_target_address, s_read_not_write, s_tx_byte,
                 s_last_byte, s_sda_in, s_scl_in};
            bus_result_q.push_back(bus_tick(t));
            n_items++;
        end
    end

    // result sink stalls
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 10) begin
            m_ready <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_sda_low, m_scl_low, m_rx_byte, m_command_done, m_status, m_busy_res};
            n_results++;
            if (m_command_done) n_done++;
            if (bus_result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: %p", got);
            end else begin
                want = bus_result_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at result %0d: want %p got %p",
                                 n_results, want, got);
                end
            end
        end
    end

    // watchdog
    int idle_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        errors = 0; n_items = 0; n_results = 0; n_done = 0;
        slave_mode = 1'b1; stuck_sda = 1'b0;
        cfg_we = 1'b0; cfg_idx = CFG_QUARTER; cfg_data = '0;
        s_valid = 1'b0; s_mode = MODE_NONE; s_target_address = '0;
        s_read_not_write = 1'b0; s_tx_byte = '0; s_last_byte = 1'b0;
        s_sda_in = 1'b1; s_scl_in = 1'b1; m_ready = 1'b0;
        bus_reset_state();
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes of the timing: minimum, all registers one
        set_timing(1, 1, 1, 1);
        cfg.quarter = 16'd1; cfg.half = 16'd1; cfg.stretch = 24'd1; cfg.pulses = 5'd1;
        // directed: ignored commands while not held, start, write, read,
        // unknown modes, stop, recovery
        slave_mode = 1'b1;
        push_cmd(MODE_WRITE, 2); push_cmd(MODE_READ, 2); push_cmd(MODE_STOP, 2);
        push_cmd(3'd6, 1); push_cmd(3'd7, 1);
        push_cmd(MODE_START, 80); push_cmd(MODE_WRITE, 80);
        push_cmd(MODE_READ, 80); push_cmd(MODE_START, 80);
        push_cmd(MODE_STOP, 20); push_cmd(MODE_RECOVER, 80);
        stuck_sda = 1'b1;
        push_cmd(MODE_RECOVER, 80); push_cmd(MODE_START, 80);
        stuck_sda = 1'b0;
        wait_drain();

        // zero quarter and half act as one, zero stretch limit, zero recovery pulses
        set_timing(0, 0, 0, 0);
        cfg.quarter = '0; cfg.half = '0; cfg.stretch = '0; cfg.pulses = '0;
        run_phase(2, 1, 1);
        wait_drain();

        set_timing(2, 3, 5, 16);
        cfg.quarter = 16'd2; cfg.half = 16'd3; cfg.stretch = 24'd5; cfg.pulses = 5'd16;
        run_phase(2, 2, 3);
        wait_drain();

        // widest stretch limit, all upper bits set
        set_timing(1, 2, 24'hFFFFFF, 31);
        cfg.quarter = 16'd1; cfg.half = 16'd2; cfg.stretch = 24'hFFFFFF;
        cfg.pulses = 5'd31;
        run_phase(1, 1, 2);
        wait_drain();

        set_timing(1, 1, 2, 4);
        cfg.quarter = 16'd1; cfg.half = 16'd1; cfg.stretch = 24'd2; cfg.pulses = 5'd4;
        run_phase(1, 1, 1);
        wait_drain();

        repeat (20) @(posedge aclk);
        $display("run covered %0d ticks and %0d results, %0d commands finished",
                 n_items, n_results, n_done);
        $display("timing settings from minimum to maximum, %0d mismatches", errors);
        if (errors == 0 && bus_result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_cfg.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_controller.sv
rtl/core/i2cm_checker.sv
dv/tb_i2c_master_controller.sv
